/* rtl/core/fwl_pkg.sv */
package fwl_pkg;

  // Input actions.
  typedef enum logic [2:0] {
    ACT_BEGIN_SCAN  = 3'd0,
    ACT_SCAN_SLOT   = 3'd1,
    ACT_FINISH_SCAN = 3'd2,
    ACT_PLAN_SAVE   = 3'd3,
    ACT_COMMIT_SAVE = 3'd4,
    ACT_ERASE_ALL   = 3'd5,
    ACT_LOCATE      = 3'd6
  } action_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_ERR    = 2'd1,
    STS_NOINIT = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FLASH_BASE   = 2'd0;
  localparam logic [1:0] CFG_SECTOR_SIZE  = 2'd1;
  localparam logic [1:0] CFG_RECORD_BYTES = 2'd2;
  localparam logic [1:0] CFG_SECTORS_USED = 2'd3;

  // Slot sizes are rounded up to a multiple of sixteen bytes.
  localparam logic [4:0] SLOT_ROUND = 5'd15;

  // Divider widths: sector size over slot size.
  localparam int unsigned DVD_W = 24;
  localparam int unsigned DVS_W = 16;

  // Main sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_DIV_WAIT,
    S_WRAP_WAIT,
    S_AW_GO,
    S_AW_WAIT,
    S_AA_GO,
    S_AA_WAIT,
    S_OUT
  } fwl_state_e;

  // Address unit phases.
  typedef enum logic [1:0] {
    AP_IDLE,
    AP_SEC,
    AP_SLOT,
    AP_SUM
  } addr_phase_e;

  // Position whose flash address is wanted.
  typedef struct packed {
    logic        start;
    logic [7:0]  sec;
    logic [15:0] slot;
  } addr_req_t;

  // Answer of the address unit, valid while done is high.
  typedef struct packed {
    logic        done;
    logic [31:0] sec_addr;
    logic [31:0] pos_addr;
  } addr_rsp_t;

endpackage

/* rtl/core/fwl_div.sv */
module fwl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fwl_pkg::DVD_W-1:0]   dividend_i,
  input  logic [fwl_pkg::DVS_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [fwl_pkg::DVD_W-1:0]   quot_o,
  output logic [fwl_pkg::DVS_W-1:0]   rem_o
);
  import fwl_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  // One quotient bit per cycle: shift in the next dividend bit and try the divisor.
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // Control: count the remaining quotient bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits as it empties.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/fwl_addr.sv */
module fwl_addr (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        flash_base_i,
  input  logic [23:0]        sector_size_i,
  input  logic [15:0]        slot_bytes_i,
  input  fwl_pkg::addr_req_t req_i,
  output fwl_pkg::addr_rsp_t rsp_o
);
  import fwl_pkg::*;

  addr_phase_e phase_q, phase_d;
  logic [7:0]  sec_q;
  logic [15:0] slot_q;
  logic [23:0] mul_a;
  logic [15:0] mul_b;
  logic [39:0] prod_full;
  logic [31:0] prod_q;
  logic [31:0] acc_q;

  // Phase register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= AP_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Phase sequence and operand selection for the shared multiplier.
  always_comb begin
    phase_d = phase_q;
    mul_a   = sector_size_i;
    mul_b   = {8'd0, sec_q};
    unique case (phase_q)
      AP_IDLE: begin
        if (req_i.start) phase_d = AP_SEC;
      end
      AP_SEC: begin
        phase_d = AP_SLOT;
      end
      AP_SLOT: begin
        mul_a   = {8'd0, slot_bytes_i};
        mul_b   = slot_q;
        phase_d = AP_SUM;
      end
      AP_SUM: begin
        phase_d = AP_IDLE;
      end
      default: phase_d = AP_IDLE;
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // Product register, then accumulate onto the base address.
  always_ff @(posedge clk_i) begin
    if (phase_q == AP_IDLE && req_i.start) begin
      sec_q  <= req_i.sec;
      slot_q <= req_i.slot;
    end
    prod_q <= prod_full[31:0];
    if (phase_q == AP_SLOT) begin
      acc_q <= flash_base_i + prod_q;
    end
  end

  assign rsp_o.done     = (phase_q == AP_SUM);
  assign rsp_o.sec_addr = acc_q;
  assign rsp_o.pos_addr = acc_q + prod_q;

endmodule

/* rtl/core/flash_wear_level_slot_log.sv */
// Channel | Direction | Handshake               | Payload
// input   | in        | in_valid_i / in_stall_o   | action, sector/slot index, header, flash_ok
// result  | out       | out_valid_o / out_stall_i | status, erase, addresses, write_seq
// config  | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item is worked on at a time; in_stall_o is high from acceptance until its result is
// registered. A save plan makes two passes of the shared multiply-add address unit, locate and
// erase-all one; a save that moves to the next sector and begin_scan (unless the slot is too
// large) also wait for the bit-serial divider. Reset is asynchronous, active low. A stalled
// result holds while the next item is taken.
module flash_wear_level_slot_log #(
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  sector_index_i,
  input  logic [15:0] slot_index_i,
  input  logic        header_valid_i,
  input  logic [15:0] header_seq_i,
  input  logic        flash_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        erase_needed_o,
  output logic [31:0] erase_addr_o,
  output logic [31:0] write_addr_o,
  output logic [15:0] write_seq_o,
  output logic [31:0] active_addr_o
);
  import fwl_pkg::*;

  localparam int unsigned SZ_W = $clog2(HEADER_BYTES + 65535 + 16) + 1;

  fwl_state_e state_q, state_d;

  // Configuration registers.
  logic [31:0] flash_base_q;
  logic [23:0] sector_size_q;
  logic [15:0] record_bytes_q;
  logic [7:0]  sectors_used_q;

  // Allocator state.
  logic [7:0]  act_sec_q;
  logic [15:0] act_slot_q;
  logic [15:0] next_seq_q;
  logic        init_q;
  logic [15:0] best_seq_q;
  logic        found_q;
  logic [15:0] slot_bytes_q;
  logic [15:0] sps_q;

  // Latched item.
  action_e     act_q;
  logic [7:0]  sec_in_q;
  logic [15:0] slot_in_q;
  logic        hv_q;
  logic [15:0] hseq_q;
  logic        fok_q;

  // Planned write position.
  logic [7:0]  plan_sec_q;
  logic [15:0] plan_slot_q;
  logic        plan_erase_q;

  // Result being assembled, and the output register.
  status_e     res_status_q;
  logic        res_erase_q;
  logic [31:0] res_eaddr_q;
  logic [31:0] res_waddr_q;
  logic [15:0] res_wseq_q;
  logic [31:0] res_aaddr_q;
  logic        out_valid_q;
  status_e     out_status_q;
  logic        out_erase_q;
  logic [31:0] out_eaddr_q;
  logic [31:0] out_waddr_q;
  logic [15:0] out_wseq_q;
  logic [31:0] out_aaddr_q;

  // Shared units.
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;
  logic [DVS_W-1:0] div_rem;
  addr_req_t        addr_req;
  addr_rsp_t        addr_rsp;

  // Decode helpers.
  logic [SZ_W-1:0] sz;
  logic            sz_ok;
  logic            scan_bad;
  logic [15:0]     seq_diff;
  logic            newer;
  logic            seq_fresh;
  logic            wrap_needed;
  logic [7:0]      ring;
  logic [8:0]      sec_inc;
  logic [15:0]     sps_sat;
  logic            out_free;

  assign sz = (SZ_W'(HEADER_BYTES) + SZ_W'(record_bytes_q) + SZ_W'(SLOT_ROUND))
              & ~SZ_W'(SLOT_ROUND);
  assign sz_ok = (sz[SZ_W-1:16] == '0) && (sz != '0);

  assign scan_bad = (sps_q == 16'd0) || init_q || (sec_in_q >= sectors_used_q) ||
                    (slot_in_q >= sps_q);
  assign seq_diff = hseq_q - best_seq_q;
  assign newer    = (seq_diff != 16'd0) && !seq_diff[15];

  assign seq_fresh   = next_seq_q <= 16'd1;
  assign wrap_needed = !seq_fresh && (({1'b0, act_slot_q} + 17'd1) >= {1'b0, sps_q});
  assign ring        = (sectors_used_q == 8'd0) ? 8'd1 : sectors_used_q;
  assign sec_inc     = {1'b0, act_sec_q} + 9'd1;
  assign sps_sat     = (div_quot[DVD_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];
  assign out_free    = !out_valid_q || !out_stall_i;

  // Divider operands: slot geometry for begin_scan, ring step for a sector change.
  always_comb begin
    if (act_q == ACT_BEGIN_SCAN) begin
      div_dividend = sector_size_q;
      div_divisor  = sz[15:0];
    end else begin
      div_dividend = DVD_W'(sec_inc);
      div_divisor  = DVS_W'(ring);
    end
  end

  fwl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Address requests: the planned slot first, then the active slot.
  always_comb begin
    addr_req.start = (state_q == S_AW_GO) || (state_q == S_AA_GO);
    if (state_q == S_AW_GO) begin
      addr_req.sec  = plan_sec_q;
      addr_req.slot = plan_slot_q;
    end else begin
      addr_req.sec  = act_sec_q;
      addr_req.slot = act_slot_q;
    end
  end

  fwl_addr u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .flash_base_i  (flash_base_q),
    .sector_size_i (sector_size_q),
    .slot_bytes_i  (slot_bytes_q),
    .req_i         (addr_req),
    .rsp_o         (addr_rsp)
  );

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer: next state and divider start.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (act_q)
          ACT_BEGIN_SCAN: begin
            if (sz_ok) begin
              div_start = 1'b1;
              state_d   = S_DIV_WAIT;
            end else begin
              state_d = S_OUT;
            end
          end
          ACT_SCAN_SLOT: begin
            state_d = S_OUT;
          end
          ACT_FINISH_SCAN: begin
            state_d = (sps_q == 16'd0) ? S_OUT : S_AA_GO;
          end
          ACT_PLAN_SAVE, ACT_COMMIT_SAVE: begin
            if (!init_q) begin
              state_d = S_OUT;
            end else if (wrap_needed) begin
              div_start = 1'b1;
              state_d   = S_WRAP_WAIT;
            end else begin
              state_d = S_AW_GO;
            end
          end
          ACT_ERASE_ALL, ACT_LOCATE: begin
            state_d = init_q ? S_AA_GO : S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_DIV_WAIT: begin
        if (div_done) state_d = S_OUT;
      end
      S_WRAP_WAIT: begin
        if (div_done) state_d = S_AW_GO;
      end
      S_AW_GO: begin
        state_d = S_AW_WAIT;
      end
      S_AW_WAIT: begin
        if (addr_rsp.done) state_d = S_AA_GO;
      end
      S_AA_GO: begin
        state_d = S_AA_WAIT;
      end
      S_AA_WAIT: begin
        if (addr_rsp.done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_base_q   <= 32'd0;
      sector_size_q  <= 24'd4096;
      record_bytes_q <= 16'd64;
      sectors_used_q <= 8'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLASH_BASE:   flash_base_q   <= cfg_wdata_i;
        CFG_SECTOR_SIZE:  sector_size_q  <= cfg_wdata_i[23:0];
        CFG_RECORD_BYTES: record_bytes_q <= cfg_wdata_i[15:0];
        CFG_SECTORS_USED: sectors_used_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Allocator state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_sec_q    <= 8'd0;
      act_slot_q   <= 16'd0;
      next_seq_q   <= 16'd1;
      init_q       <= 1'b0;
      best_seq_q   <= 16'd0;
      found_q      <= 1'b0;
      slot_bytes_q <= 16'd0;
      sps_q        <= 16'd0;
    end else begin
      if (state_q == S_EXEC) begin
        unique case (act_q)
          ACT_BEGIN_SCAN: begin
            init_q       <= 1'b0;
            found_q      <= 1'b0;
            best_seq_q   <= 16'd0;
            act_sec_q    <= 8'd0;
            act_slot_q   <= 16'd0;
            next_seq_q   <= 16'd1;
            sps_q        <= 16'd0;
            slot_bytes_q <= sz_ok ? sz[15:0] : 16'd0;
          end
          ACT_SCAN_SLOT: begin
            if (!scan_bad && hv_q && (!found_q || newer)) begin
              best_seq_q <= hseq_q;
              act_sec_q  <= sec_in_q;
              act_slot_q <= slot_in_q;
              found_q    <= 1'b1;
            end
          end
          ACT_FINISH_SCAN: begin
            if (sps_q != 16'd0) begin
              init_q <= 1'b1;
              if (found_q) begin
                next_seq_q <= best_seq_q + 16'd1;
              end else begin
                act_sec_q  <= 8'd0;
                act_slot_q <= 16'd0;
                next_seq_q <= 16'd1;
              end
            end
          end
          ACT_ERASE_ALL: begin
            if (init_q) begin
              act_sec_q  <= 8'd0;
              act_slot_q <= 16'd0;
              next_seq_q <= 16'd1;
            end
          end
          default: ;
        endcase
      end
      // Slots per sector once the division completes.
      if (state_q == S_DIV_WAIT && div_done) begin
        sps_q <= sps_sat;
      end
      // A successful commit moves the active slot to the planned one.
      if (state_q == S_AW_WAIT && addr_rsp.done && act_q == ACT_COMMIT_SAVE && fok_q) begin
        act_sec_q  <= plan_sec_q;
        act_slot_q <= plan_slot_q;
        next_seq_q <= next_seq_q + 16'd1;
      end
    end
  end

  // Item latch, save plan and result assembly.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      act_q        <= action_e'(action_i);
      sec_in_q     <= sector_index_i;
      slot_in_q    <= slot_index_i;
      hv_q         <= header_valid_i;
      hseq_q       <= header_seq_i;
      fok_q        <= flash_ok_i;
      res_status_q <= STS_OK;
      res_erase_q  <= 1'b0;
      res_eaddr_q  <= 32'd0;
      res_waddr_q  <= 32'd0;
      res_wseq_q   <= 16'd0;
      res_aaddr_q  <= 32'd0;
    end
    if (state_q == S_EXEC) begin
      unique case (act_q)
        ACT_BEGIN_SCAN: begin
          if (!sz_ok) res_status_q <= STS_ERR;
        end
        ACT_SCAN_SLOT: begin
          if (scan_bad) res_status_q <= STS_ERR;
        end
        ACT_FINISH_SCAN: begin
          if (sps_q == 16'd0 || !found_q) res_status_q <= STS_ERR;
        end
        ACT_PLAN_SAVE, ACT_COMMIT_SAVE: begin
          if (!init_q) begin
            res_status_q <= STS_NOINIT;
          end else if (seq_fresh) begin
            plan_sec_q   <= act_sec_q;
            plan_slot_q  <= act_slot_q;
            plan_erase_q <= 1'b1;
          end else if (wrap_needed) begin
            plan_slot_q  <= 16'd0;
            plan_erase_q <= 1'b1;
          end else begin
            plan_sec_q   <= act_sec_q;
            plan_slot_q  <= act_slot_q + 16'd1;
            plan_erase_q <= 1'b0;
          end
        end
        ACT_ERASE_ALL, ACT_LOCATE: begin
          if (!init_q) res_status_q <= STS_NOINIT;
        end
        default: res_status_q <= STS_ERR;
      endcase
    end
    // Geometry check once the slot count is known.
    if (state_q == S_DIV_WAIT && div_done && sps_sat == 16'd0) begin
      res_status_q <= STS_ERR;
    end
    // Next sector in the ring.
    if (state_q == S_WRAP_WAIT && div_done) begin
      plan_sec_q <= div_rem[7:0];
    end
    // Write plan addresses.
    if (state_q == S_AW_WAIT && addr_rsp.done) begin
      res_erase_q <= plan_erase_q;
      res_eaddr_q <= plan_erase_q ? addr_rsp.sec_addr : 32'd0;
      res_waddr_q <= addr_rsp.pos_addr;
      res_wseq_q  <= next_seq_q;
      if (act_q == ACT_COMMIT_SAVE && !fok_q) res_status_q <= STS_ERR;
    end
    // Active slot address.
    if (state_q == S_AA_WAIT && addr_rsp.done) begin
      res_aaddr_q <= addr_rsp.pos_addr;
    end
    // Output register payload.
    if (state_q == S_OUT && out_free) begin
      out_status_q <= res_status_q;
      out_erase_q  <= res_erase_q;
      out_eaddr_q  <= res_eaddr_q;
      out_waddr_q  <= res_waddr_q;
      out_wseq_q   <= res_wseq_q;
      out_aaddr_q  <= res_aaddr_q;
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign erase_needed_o = out_erase_q;
  assign erase_addr_o   = out_eaddr_q;
  assign write_addr_o   = out_waddr_q;
  assign write_seq_o    = out_wseq_q;
  assign active_addr_o  = out_aaddr_q;

endmodule
